// File: rtl/relu_dense_layer_sgd_assert.svh
// Assertion macros for the dense ReLU layer with gradient descent training.
// Used by the port checker; needs clk and arst_n in the scope of each use.
`ifndef RELU_DENSE_LAYER_SGD_ASSERT_SVH
`define RELU_DENSE_LAYER_SGD_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDSGD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RDSGD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rdsgd_pkg.sv
// Shared types, codes and arithmetic helpers of the dense ReLU layer.
// No dependencies; imported by every module of the layer.
package rdsgd_pkg;

	localparam int LANES      = 16;
	localparam int ACC_W      = 40;
	localparam int FIFO_DEPTH = 2 * LANES;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [2:0] CMD_LOAD_W = 3'd0;
	localparam logic [2:0] CMD_LOAD_B = 3'd1;
	localparam logic [2:0] CMD_FWD    = 3'd2;
	localparam logic [2:0] CMD_GRAD   = 3'd3;
	localparam logic [2:0] CMD_READ_W = 3'd4;

	localparam logic [1:0] KIND_ACT   = 2'd0;
	localparam logic [1:0] KIND_IGRAD = 2'd1;
	localparam logic [1:0] KIND_WREAD = 2'd2;

	localparam logic [1:0] CFG_IN_COUNT  = 2'd0;
	localparam logic [1:0] CFG_OUT_COUNT = 2'd1;
	localparam logic [1:0] CFG_RATE      = 2'd2;

	localparam logic signed [15:0] BIAS_RESET = 16'sd410;

	typedef struct packed {
		logic signed [15:0] value;
		logic [3:0]         index;
		logic [1:0]         kind;
		logic               last;
	} result_t;

	typedef struct packed {
		logic shift_x;
		logic shift_a;
		logic clr_a;
	} cell_ctl_t;

	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		if (v > 48'sd32767) begin
			return 16'sh7fff;
		end else if (v < -48'sd32768) begin
			return 16'sh8000;
		end else begin
			return v[15:0];
		end
	endfunction

	// Round half up, then shift right arithmetically.
	function automatic logic signed [47:0] rnd_shift(input logic signed [47:0] p,
			input int s);
		logic signed [47:0] half;
		half = 48'sd1 <<< (s - 1);
		return (p + half) >>> s;
	endfunction

endpackage

// File: rtl/rdsgd_cell.sv
// One cell of the input ring: holds a saved input and an input-gradient sum.
// Depends on rdsgd_pkg; instantiated in a row by the layer top level.
module rdsgd_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rdsgd_pkg::cell_ctl_t                ctl,
	input  logic                                in_ring,
	input  logic                                load_x,
	input  logic signed [15:0]                  load_val,
	input  logic signed [15:0]                  x_nxt,
	input  logic signed [rdsgd_pkg::ACC_W-1:0]  a_nxt,
	output logic signed [15:0]                  x,
	output logic signed [rdsgd_pkg::ACC_W-1:0]  a
);
	import rdsgd_pkg::*;

	logic signed [15:0]      x_q;
	logic signed [ACC_W-1:0] a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			a_q <= '0;
		end else begin
			if (load_x) begin
				x_q <= load_val;
			end else if (ctl.shift_x && in_ring) begin
				x_q <= x_nxt;
			end
			if (ctl.clr_a) begin
				a_q <= '0;
			end else if (ctl.shift_a && in_ring) begin
				a_q <= a_nxt;
			end
		end
	end

	assign x = x_q;
	assign a = a_q;
endmodule

// File: rtl/rdsgd_ofifo.sv
// Result queue of the layer: holds finished result beats until taken.
// Depends on rdsgd_pkg for the result type and depth.
module rdsgd_ofifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  rdsgd_pkg::result_t              push_data,
	input  logic                            pop,
	output rdsgd_pkg::result_t              head,
	output logic [rdsgd_pkg::FIFO_CW-1:0]   count
);
	import rdsgd_pkg::*;

	result_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wp_q;
	logic [FIFO_AW-1:0]   rp_q;
	logic [FIFO_CW-1:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign head  = mem_q[rp_q];
	assign count = cnt_q;
endmodule

// File: rtl/relu_dense_layer_sgd.sv
// Dense ReLU layer with gradient descent; loads and plain elements complete when taken.
// Readback: the weight is registered out of memory, then queued as a result. A forward
// or gradient run steps one weight per cycle through the operand, product and sum stages,
// and a gradient run then emits one input gradient per input. Reset clears control, sets
// biases to 410, saved inputs and flags to zero; weights and gradients hold nothing until written.
module relu_dense_layer_sgd #(
	parameter int MAX_IN  = 16,
	parameter int MAX_OUT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [2:0]         command,
	input  logic [3:0]         row,
	input  logic [3:0]         col,
	input  logic signed [15:0] value,
	input  logic               last,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [15:0] result_value,
	output logic [3:0]         result_index,
	output logic [1:0]         kind,
	output logic               end_of_run,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import rdsgd_pkg::*;

	localparam int NI_LIM = (MAX_IN < LANES) ? MAX_IN : LANES;
	localparam int NO_LIM = (MAX_OUT < LANES) ? MAX_OUT : LANES;
	localparam int NOW    = $clog2(NO_LIM);
	localparam int DEPTH  = MAX_IN * MAX_OUT;
	localparam int AW     = $clog2(DEPTH);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [4:0]  in_cnt_q;
	logic [4:0]  out_cnt_q;
	logic [15:0] lr_q;
	logic [4:0]  ni;
	logic [4:0]  no;

	logic [2:0]  state_q;
	logic        bwd_q;
	logic [3:0]  i_q;
	logic [3:0]  j_q;
	logic [3:0]  e_q;
	logic        rd_ok_q;
	logic [3:0]  rd_col_q;
	logic        acc;

	logic signed [15:0]      bias_q [NO_LIM];
	logic                    flag_q [NO_LIM];
	logic signed [15:0]      grad_q [NO_LIM];
	logic signed [15:0]      wmem [DEPTH];
	logic signed [15:0]      w_rd_q;
	logic [AW-1:0]           raddr;
	logic [AW-1:0]           waddr;
	logic signed [15:0]      wdata;
	logic                    we;

	logic [AW-1:0]           addr_a;
	logic signed [15:0]      zg_a;

	logic                    v_s1;
	logic [3:0]              i_s1;
	logic                    j0_s1;
	logic                    jl_s1;
	logic                    il_s1;
	logic signed [15:0]      x_s1;
	logic signed [15:0]      zg_s1;
	logic signed [32:0]      lg_s1;
	logic [AW-1:0]           addr_s1;

	logic                    v_s2;
	logic [3:0]              i_s2;
	logic                    j0_s2;
	logic                    jl_s2;
	logic                    il_s2;
	logic signed [31:0]      prod_s2;
	logic signed [47:0]      upd_s2;
	logic signed [15:0]      w_s2;
	logic [AW-1:0]           addr_s2;

	logic signed [31:0]      prod_b;
	logic signed [48:0]      lgx_b;
	logic signed [ACC_W-1:0] z_q;
	logic signed [ACC_W-1:0] zsum;
	logic signed [ACC_W-1:0] a_tail;

	cell_ctl_t               ctl;
	logic signed [15:0]      x_c [NI_LIM];
	logic signed [ACC_W-1:0] a_c [NI_LIM];

	logic                    push;
	result_t                 push_data;
	result_t                 head;
	logic [FIFO_CW-1:0]      fcount;
	logic                    pop;

	assign ni = (in_cnt_q == 5'd0) ? 5'd1 :
		((in_cnt_q > 5'(NI_LIM)) ? 5'(NI_LIM) : in_cnt_q);
	assign no = (out_cnt_q == 5'd0) ? 5'd1 :
		((out_cnt_q > 5'(NO_LIM)) ? 5'(NO_LIM) : out_cnt_q);

	assign cfg_ready  = 1'b1;
	assign item_stall = !((state_q == ST_IDLE) && (fcount <= FIFO_CW'(LANES)));
	assign acc        = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= 5'd16;
			out_cnt_q <= 5'd16;
			lr_q      <= 16'd655;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IN_COUNT:  in_cnt_q  <= cfg_data[4:0];
				CFG_OUT_COUNT: out_cnt_q <= cfg_data[4:0];
				CFG_RATE:      lr_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			bwd_q    <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			e_q      <= '0;
			rd_ok_q  <= 1'b0;
			rd_col_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						rd_ok_q  <= (32'(row) < MAX_OUT) && (32'(col) < MAX_IN);
						rd_col_q <= col;
						i_q      <= '0;
						j_q      <= '0;
						case (command)
							CMD_READ_W: state_q <= ST_READ;
							CMD_FWD: begin
								if (last) begin
									state_q <= ST_RUN;
									bwd_q   <= 1'b0;
								end
							end
							CMD_GRAD: begin
								if (last) begin
									state_q <= ST_RUN;
									bwd_q   <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				ST_READ: state_q <= ST_IDLE;
				ST_RUN: begin
					if ({1'b0, j_q} == ni - 5'd1) begin
						j_q <= '0;
						if ({1'b0, i_q} == no - 5'd1) begin
							state_q <= ST_DRAIN;
						end else begin
							i_q <= i_q + 4'd1;
						end
					end else begin
						j_q <= j_q + 4'd1;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						e_q     <= '0;
						state_q <= bwd_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					e_q <= e_q + 4'd1;
					if ({1'b0, e_q} == ni - 5'd1) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Weight memory.
	assign addr_a = AW'(32'(i_q) * MAX_IN + 32'(j_q));
	assign raddr  = (state_q == ST_RUN) ? addr_a : AW'(32'(row) * MAX_IN + 32'(col));
	assign we     = (acc && (command == CMD_LOAD_W) && (32'(row) < MAX_OUT)
		&& (32'(col) < MAX_IN)) || (v_s2 && bwd_q);
	assign waddr  = (v_s2 && bwd_q) ? addr_s2 : AW'(32'(row) * MAX_IN + 32'(col));
	assign wdata  = (v_s2 && bwd_q) ? sat16(48'(w_s2) - rnd_shift(upd_s2, 28)) : value;

	always_ff @(posedge clk) begin
		if (we) begin
			wmem[waddr] <= wdata;
		end
		w_rd_q <= wmem[raddr];
	end

	// Stage one: operands of the current weight.
	assign zg_a = flag_q[i_q[NOW-1:0]] ? grad_q[i_q[NOW-1:0]] : 16'sd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_RUN);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		i_s1    <= i_q;
		j0_s1   <= (j_q == 4'd0);
		jl_s1   <= ({1'b0, j_q} == ni - 5'd1);
		il_s1   <= ({1'b0, i_q} == no - 5'd1);
		x_s1    <= x_c[0];
		zg_s1   <= zg_a;
		lg_s1   <= $signed({1'b0, lr_q}) * zg_a;
		addr_s1 <= addr_a;
	end

	// Stage two: products.
	assign prod_b = w_rd_q * (bwd_q ? zg_s1 : x_s1);
	assign lgx_b  = lg_s1 * x_s1;

	always_ff @(posedge clk) begin
		i_s2    <= i_s1;
		j0_s2   <= j0_s1;
		jl_s2   <= jl_s1;
		il_s2   <= il_s1;
		prod_s2 <= prod_b;
		upd_s2  <= lgx_b[47:0];
		w_s2    <= w_rd_q;
		addr_s2 <= addr_s1;
	end

	// Stage three: forward sums.
	assign zsum = (j0_s2 ? (ACC_W'(bias_q[i_s2[NOW-1:0]]) <<< 12) : z_q)
		+ ACC_W'(prod_s2);

	always_ff @(posedge clk) begin
		if (v_s2 && !bwd_q) begin
			z_q <= zsum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NO_LIM; k++) begin
				bias_q[k] <= BIAS_RESET;
				flag_q[k] <= 1'b0;
			end
		end else begin
			if (acc && (command == CMD_LOAD_B) && (32'(row) < NO_LIM)) begin
				bias_q[row[NOW-1:0]] <= value;
			end else if (v_s1 && bwd_q && j0_s1) begin
				bias_q[i_s1[NOW-1:0]] <= sat16(48'(bias_q[i_s1[NOW-1:0]])
					- rnd_shift(48'(lg_s1), 16));
			end
			if (v_s2 && !bwd_q && jl_s2) begin
				flag_q[i_s2[NOW-1:0]] <= (zsum > 0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (command == CMD_GRAD) && ({1'b0, row} < no)) begin
			grad_q[row[NOW-1:0]] <= value;
		end
	end

	// Ring of input cells.
	assign ctl.shift_x = (state_q == ST_RUN);
	assign ctl.shift_a = (v_s2 && bwd_q) || (state_q == ST_EMIT);
	assign ctl.clr_a   = acc && (command == CMD_GRAD) && last;
	assign a_tail      = a_c[0] + ((v_s2 && bwd_q) ? ACC_W'(prod_s2) : '0);

	for (genvar k = 0; k < NI_LIM; k++) begin : g_cell
		logic signed [15:0]      x_nxt;
		logic signed [ACC_W-1:0] a_nxt;

		if (k == NI_LIM - 1) begin : g_tail
			assign x_nxt = x_c[0];
			assign a_nxt = a_tail;
		end else begin : g_mid
			assign x_nxt = (5'(k) == ni - 5'd1) ? x_c[0] : x_c[k+1];
			assign a_nxt = (5'(k) == ni - 5'd1) ? a_tail : a_c[k+1];
		end

		rdsgd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.in_ring  (5'(k) < ni),
			.load_x   (acc && (command == CMD_FWD) && ({1'b0, col} < ni)
				&& (32'(col) == k)),
			.load_val (value),
			.x_nxt    (x_nxt),
			.a_nxt    (a_nxt),
			.x        (x_c[k]),
			.a        (a_c[k])
		);
	end

	// Result beats.
	always_comb begin
		push      = 1'b0;
		push_data = '0;
		if (state_q == ST_READ) begin
			push            = 1'b1;
			push_data.value = rd_ok_q ? w_rd_q : 16'sd0;
			push_data.index = rd_col_q;
			push_data.kind  = KIND_WREAD;
			push_data.last  = 1'b1;
		end else if (state_q == ST_EMIT) begin
			push            = 1'b1;
			push_data.value = sat16(rnd_shift(48'(a_c[0]), 12));
			push_data.index = e_q;
			push_data.kind  = KIND_IGRAD;
			push_data.last  = ({1'b0, e_q} == ni - 5'd1);
		end else if (v_s2 && !bwd_q && jl_s2) begin
			push            = 1'b1;
			push_data.value = (zsum > 0) ? sat16(rnd_shift(48'(zsum), 12)) : 16'sd0;
			push_data.index = i_s2;
			push_data.kind  = KIND_ACT;
			push_data.last  = il_s2;
		end
	end

	assign pop = result_valid && !result_stall;

	rdsgd_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.count     (fcount)
	);

	assign result_valid = (fcount != '0);
	assign result_value = head.value;
	assign result_index = head.index;
	assign kind         = head.kind;
	assign end_of_run   = head.last;
endmodule

// File: rtl/rdsgd_checker.sv
// Port checker for the dense ReLU layer, bound to its top level.
// Depends on relu_dense_layer_sgd_assert.svh and rdsgd_pkg.
`include "relu_dense_layer_sgd_assert.svh"

module rdsgd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input logic [2:0]         command,
	input logic               last,
	input logic               result_valid,
	input logic               result_stall,
	input logic signed [15:0] result_value,
	input logic [1:0]         kind,
	input logic               end_of_run,
	input logic               cfg_valid,
	input logic               cfg_ready
);
	import rdsgd_pkg::*;

	`RDSGD_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(result_value), "stalled result beat changed")
	`RDSGD_ASSERT_NEXT(a_busy, item_valid && !item_stall && (command == CMD_READ_W || ((command == CMD_FWD || command == CMD_GRAD) && last)), item_stall, "item taken while a run starts")
	`RDSGD_ASSERT_NOW(a_cfg, cfg_valid, cfg_ready, "configuration write refused")
	`RDSGD_ASSERT_NOW(a_rdend, result_valid && kind == KIND_WREAD, end_of_run, "weight readback without end of run")
endmodule

bind relu_dense_layer_sgd rdsgd_checker u_rdsgd_checker (.*);

// File: dv/tb_relu_dense_layer_sgd.sv
// Self-checking testbench for the dense ReLU layer with gradient descent training.
// Drives command beats and register writes, predicts every result and compares it.
// Depends on rdsgd_pkg and the relu_dense_layer_sgd top level only.
`timescale 1ns / 100ps

module tb_relu_dense_layer_sgd;
	import rdsgd_pkg::*;

	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
	localparam int RUN_SETTLE = 320;
	localparam int DIRECTED_ROWS = 14;

	typedef struct {
		logic [2:0]         cmd;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [15:0] val;
		logic               last;
	} beat_t;

	typedef struct {
		logic signed [15:0] val;
		logic [3:0]         idx;
		logic [1:0]         knd;
		logic               eor;
	} outcome_t;

	typedef struct {
		beat_t              b;
		logic               typed;
		logic signed [15:0] want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	logic [2:0] command;
	logic [3:0] row;
	logic [3:0] col;
	logic signed [15:0] value;
	logic last;
	logic result_valid;
	logic result_stall;
	logic signed [15:0] result_value;
	logic [3:0] result_index;
	logic [1:0] kind;
	logic end_of_run;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	logic signed [15:0] weights [16][16];
	logic signed [15:0] biases [16];
	logic signed [15:0] inputs_kept [16];
	logic               pos_flag [16];
	logic signed [15:0] grads_kept [16];
	int unsigned in_reg;
	int unsigned out_reg;
	longint lrate;

	outcome_t pending_results[$];
	int fail_count;
	int burst_left;
	int stall_mode;
	int stall_left;

	stim_row_t directed [DIRECTED_ROWS];

	relu_dense_layer_sgd u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.command(command), .row(row), .col(col), .value(value), .last(last),
		.result_valid(result_valid), .result_stall(result_stall),
		.result_value(result_value), .result_index(result_index),
		.kind(kind), .end_of_run(end_of_run),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic signed [15:0] clip16(input longint v);
		if (v > 32767) begin
			return 16'sh7fff;
		end else if (v < -32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic longint round_shift(input longint p, input int s);
		return (p + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic int clamp_count(input int unsigned r);
		if (r < 1) begin
			return 1;
		end else if (r > 16) begin
			return 16;
		end
		return int'(r);
	endfunction

	function automatic void queue_result(input logic signed [15:0] v, input int idx,
			input logic [1:0] k, input logic e);
		outcome_t o;
		o.val = v;
		o.idx = idx[3:0];
		o.knd = k;
		o.eor = e;
		pending_results = {pending_results, o};
	endfunction

	// Updates the layer state for one accepted beat and queues the results it causes.
	function automatic void layer_predict(input beat_t b);
		int ni;
		int no;
		longint z;
		longint s;
		longint lg;
		logic signed [15:0] zg [16];
		ni = clamp_count(in_reg);
		no = clamp_count(out_reg);
		case (b.cmd)
			CMD_LOAD_W: weights[b.row][b.col] = b.val;
			CMD_LOAD_B: biases[b.row] = b.val;
			CMD_READ_W: queue_result(weights[b.row][b.col], int'(b.col), KIND_WREAD, 1'b1);
			CMD_FWD: begin
				if (int'(b.col) < ni) inputs_kept[b.col] = b.val;
				if (b.last) begin
					for (int i = 0; i < no; i++) begin
						z = longint'(biases[i]) * 4096;
						for (int j = 0; j < ni; j++)
							z += longint'(weights[i][j]) * longint'(inputs_kept[j]);
						pos_flag[i] = z > 0;
						queue_result(z > 0 ? clip16((z + 2048) >>> 12) : 16'sd0, i,
							KIND_ACT, i == no - 1);
					end
				end
			end
			CMD_GRAD: begin
				if (int'(b.row) < no) grads_kept[b.row] = b.val;
				if (b.last) begin
					for (int i = 0; i < no; i++) zg[i] = pos_flag[i] ? grads_kept[i] : 16'sd0;
					for (int j = 0; j < ni; j++) begin
						s = 0;
						for (int i = 0; i < no; i++)
							s += longint'(zg[i]) * longint'(weights[i][j]);
						queue_result(clip16(round_shift(s, 12)), j, KIND_IGRAD, j == ni - 1);
					end
					for (int i = 0; i < no; i++) begin
						lg = lrate * longint'(zg[i]);
						for (int j = 0; j < ni; j++)
							weights[i][j] = clip16(longint'(weights[i][j]) -
								round_shift(lg * longint'(inputs_kept[j]), 28));
						biases[i] = clip16(longint'(biases[i]) - round_shift(lg, 16));
					end
				end
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk) begin
		outcome_t o;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result beat, value", int'(result_value), 0);
			end else begin
				o = pending_results.pop_front();
				if (result_value !== o.val)
					report_mismatch("result_value", int'(result_value), int'(o.val));
				if (result_index !== o.idx)
					report_mismatch("result_index", int'(result_index), int'(o.idx));
				if (kind !== o.knd) report_mismatch("kind", int'(kind), int'(o.knd));
				if (end_of_run !== o.eor)
					report_mismatch("end_of_run", int'(end_of_run), int'(o.eor));
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(4, 60);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= 1'($urandom_range(0, 1));
			2: result_stall <= ($urandom_range(0, 7) != 0);
			default: result_stall <= ($urandom_range(0, 5) == 0);
		endcase
	end

	task automatic send_beat(input beat_t b, input logic typed = 1'b0,
			input logic signed [15:0] want = 16'sd0);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 2) != 0) begin
				item_valid = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
		burst_left--;
		item_valid = 1'b1;
		command = b.cmd;
		row = b.row;
		col = b.col;
		value = b.val;
		last = b.last;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		layer_predict(b);
		if (typed) begin
			pending_results[pending_results.size() - 1].val = want;
		end
		@(negedge clk);
		item_valid = 1'b0;
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_IN_COUNT: in_reg = 32'(data[4:0]);
			CFG_OUT_COUNT: out_reg = 32'(data[4:0]);
			CFG_RATE: lrate = longint'(data);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (RUN_SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] pick_value;
		if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 65535));
		return 16'($signed($urandom_range(0, 8191)) - 4096);
	endfunction

	function automatic beat_t make_beat(input logic [2:0] c, input int r, input int k,
			input logic signed [15:0] v, input logic l);
		beat_t b;
		b.cmd = c;
		b.row = r[3:0];
		b.col = k[3:0];
		b.val = v;
		b.last = l;
		return b;
	endfunction

	task automatic random_phase(input int beats);
		int sent;
		int sel;
		int ni;
		int no;
		ni = clamp_count(in_reg);
		no = clamp_count(out_reg);
		sent = 0;
		while (sent < beats) begin
			sel = $urandom_range(0, 99);
			if (sel < 33) begin
				for (int j = 0; j < ni; j++) begin
					if (j == ni - 1 || $urandom_range(0, 4) != 0) begin
						send_beat(make_beat(CMD_FWD, $urandom_range(0, 15), j, pick_value(),
							j == ni - 1));
						sent++;
					end
				end
			end else if (sel < 63) begin
				for (int i = 0; i < no; i++) begin
					if (i == no - 1 || $urandom_range(0, 4) != 0) begin
						send_beat(make_beat(CMD_GRAD, i, $urandom_range(0, 15), pick_value(),
							i == no - 1));
						sent++;
					end
				end
			end else begin
				if (sel < 73) begin
					send_beat(make_beat(CMD_LOAD_W, $urandom_range(0, 15), $urandom_range(0, 15),
						pick_value(), 1'($urandom_range(0, 1))));
				end else if (sel < 80) begin
					send_beat(make_beat(CMD_LOAD_B, $urandom_range(0, 15), $urandom_range(0, 15),
						pick_value(), 1'($urandom_range(0, 1))));
				end else if (sel < 88) begin
					send_beat(make_beat(CMD_READ_W, $urandom_range(0, 15), $urandom_range(0, 15),
						16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1))));
				end else if (sel < 93) begin
					send_beat(make_beat(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
						$urandom_range(0, 15), $urandom_range(0, 15),
						16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1))));
				end else begin
					send_beat(make_beat($urandom_range(0, 1) ? CMD_FWD : CMD_GRAD,
						$urandom_range(0, 15), $urandom_range(0, 15), pick_value(),
						1'($urandom_range(0, 1))));
				end
				sent++;
			end
		end
		drain();
	endtask

	initial begin
		#3000000;
		$display("relu_dense_layer_sgd verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		command = CMD_LOAD_W;
		row = '0;
		col = '0;
		value = '0;
		last = 1'b0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_IN_COUNT;
		cfg_data = '0;
		fail_count = 0;
		burst_left = 0;
		stall_mode = 0;
		stall_left = 0;
		in_reg = 16;
		out_reg = 16;
		lrate = 655;
		for (int i = 0; i < 16; i++) begin
			biases[i] = BIAS_RESET;
			inputs_kept[i] = '0;
			pos_flag[i] = 1'b0;
			grads_kept[i] = '0;
			for (int j = 0; j < 16; j++) weights[i][j] = '0;
		end

		directed[0]  = '{make_beat(CMD_LOAD_W, 0, 0, 16'sh7fff, 1'b0), 1'b0, 16'sd0};
		directed[1]  = '{make_beat(CMD_READ_W, 0, 0, 16'sd0, 1'b0), 1'b1, 16'sh7fff};
		directed[2]  = '{make_beat(CMD_LOAD_W, 15, 15, 16'sh8000, 1'b1), 1'b0, 16'sd0};
		directed[3]  = '{make_beat(CMD_READ_W, 15, 15, 16'shffff, 1'b1), 1'b1, 16'sh8000};
		directed[4]  = '{make_beat(CMD_LOAD_B, 0, 7, 16'sh7fff, 1'b0), 1'b0, 16'sd0};
		directed[5]  = '{make_beat(CMD_LOAD_B, 15, 0, 16'sh8000, 1'b0), 1'b0, 16'sd0};
		directed[6]  = '{make_beat(CMD_SPARE_FIRST, 3, 3, 16'sd1, 1'b1), 1'b0, 16'sd0};
		directed[7]  = '{make_beat(CMD_SPARE_LAST, 15, 15, 16'shffff, 1'b1), 1'b0, 16'sd0};
		directed[8]  = '{make_beat(CMD_FWD, 0, 0, 16'sh7fff, 1'b0), 1'b0, 16'sd0};
		directed[9]  = '{make_beat(CMD_FWD, 0, 15, 16'sh8000, 1'b1), 1'b0, 16'sd0};
		directed[10] = '{make_beat(CMD_GRAD, 0, 0, 16'sh7fff, 1'b0), 1'b0, 16'sd0};
		directed[11] = '{make_beat(CMD_GRAD, 15, 0, 16'sh8000, 1'b1), 1'b0, 16'sd0};
		directed[12] = '{make_beat(CMD_READ_W, 0, 0, 16'sd0, 1'b0), 1'b0, 16'sd0};
		directed[13] = '{make_beat(CMD_FWD, 0, 3, 16'sd4096, 1'b1), 1'b0, 16'sd0};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every weight and gradient entry is written before anything can read it.
		for (int i = 0; i < 16; i++) begin
			for (int j = 0; j < 16; j++)
				send_beat(make_beat(CMD_LOAD_W, i, j,
					16'($signed($urandom_range(0, 2047)) - 1024), 1'b0));
			send_beat(make_beat(CMD_GRAD, i, 0, pick_value(), 1'b0));
		end
		send_beat(make_beat(CMD_READ_W, 7, 9, 16'sd0, 1'b0));

		for (int n = 0; n < DIRECTED_ROWS; n++)
			send_beat(directed[n].b, directed[n].typed, directed[n].want);
		drain();

		random_phase(40);
		write_register(CFG_IN_COUNT, 16'd1);
		write_register(CFG_OUT_COUNT, 16'd1);
		write_register(CFG_RATE, 16'hffff);
		random_phase(30);
		write_register(CFG_IN_COUNT, 16'd0);
		write_register(CFG_OUT_COUNT, 16'd31);
		write_register(CFG_RATE, 16'h0000);
		random_phase(30);
		write_register(CFG_IN_COUNT, 16'd5);
		write_register(CFG_OUT_COUNT, 16'd7);
		write_register(CFG_RATE, 16'($urandom_range(0, 65535)));
		random_phase(20);
		while (pending_results.size() != 0) @(posedge clk);
		@(negedge clk);
		random_phase(20);
		write_register(CFG_IN_COUNT, 16'd17);
		write_register(CFG_OUT_COUNT, 16'd0);
		write_register(CFG_RATE, 16'($urandom_range(0, 65535)));
		random_phase(30);
		write_register(CFG_IN_COUNT, 16'd16);
		write_register(CFG_OUT_COUNT, 16'd16);
		write_register(CFG_RATE, 16'($urandom_range(0, 65535)));
		random_phase(50);

		if (fail_count == 0) begin
			$display("relu_dense_layer_sgd verification clean");
		end else begin
			$display("relu_dense_layer_sgd verification failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rdsgd_pkg.sv
rtl/rdsgd_cell.sv
rtl/rdsgd_ofifo.sv
rtl/relu_dense_layer_sgd.sv
rtl/rdsgd_checker.sv
dv/tb_relu_dense_layer_sgd.sv
